@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the core RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, clocked on clk_i, disabled while rst_ni is low
`define SWA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle
`define SWA_ASSERT_IMP(lbl, ante, cons) \
  `SWA_ASSERT(lbl, (ante) |-> (cons))

// Antecedent implies consequent in the next cycle
`define SWA_ASSERT_NXT(lbl, ante, cons) \
  `SWA_ASSERT(lbl, (ante) |=> (cons))

`endif

@@ rtl/core/swa_pkg.sv @@
// Package: sizes and types of the sliding window average/min/max core.
package swa_pkg;

  localparam int WINDOW_MAX  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int AXES        = 3;
  localparam int ADDR_W      = $clog2(WINDOW_MAX);
  localparam int LEN_W       = 11;
  localparam int SUM_W       = SAMPLE_BITS + ADDR_W;
  localparam int DIV_STEPS   = SUM_W;
  localparam int STEP_W      = $clog2(DIV_STEPS + 2);
  localparam int REM_W       = ADDR_W + 1;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

endpackage

@@ rtl/core/sliding_window_avg_min_max_core.sv @@
// Top level: sliding window mean, minimum and maximum of three-axis samples.
//
// Input stream s_axis_*: one transfer carries x, y and z samples (signed Q3.12).
// Output stream m_axis_*: one transfer carries, per axis, the new sample, the
// window mean (truncated toward zero), the window minimum and maximum.
// Config: cfg_we_i/cfg_wdata_i write the window length L (0 acts as 1, above
// 1024 acts as 1024); a write restarts filling and must only come while idle.
// The first L samples after reset or a length write only fill the window and
// give no output; every later sample gives one output transfer.
// Timing: after an input transfer s_axis_tready stays low through the read and
// update states while the window fills, and otherwise until the scan, the
// divider and the output load are done: the scan over the window memory reads
// one entry per cycle, while one shared restoring divider forms the three means in turn.
// The result sits in an output register; the core takes the next sample while
// it waits, and if the receiver still stalls when the next result is ready,
// the core holds that result until the register frees.
// Reset: length returns to 16, fill count, write slot and sums clear; the
// window memory is not cleared, as no unwritten entry is ever read.
module sliding_window_avg_min_max_core
  import swa_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write
  input  logic                        cfg_we_i,
  input  logic [LEN_W-1:0]            cfg_wdata_i,
  // Sample input
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [3*SAMPLE_BITS-1:0]    s_axis_tdata,  // x_sample, y_sample, z_sample
  // Result output
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // x_now, x_mean, x_least, x_most, y_now, y_mean, y_least, y_most,
  // z_now, z_mean, z_least, z_most
  output logic [12*SAMPLE_BITS-1:0]   m_axis_tdata
);

`include "assert_macros.svh"

  // Sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDOLD  = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [LEN_W-1:0]  len_q;
  logic [LEN_W-1:0]  n_eff;
  logic [ADDR_W-1:0] slot_q;
  logic [ADDR_W-1:0] slot_eff;
  logic [LEN_W-1:0]  slot_inc;
  logic [LEN_W-1:0]  items_q;
  logic              full_q;
  sample_t           now_q   [AXES];
  sum_t              sums_q  [AXES];
  sample_t           lo_q    [AXES];
  sample_t           hi_q    [AXES];
  sample_t           mean_q  [AXES];
  logic [ADDR_W-1:0] scan_addr_q;
  logic              scan_vld_q;
  logic              scan_first_q;
  logic              scan_last;
  logic              in_xfer;
  logic              out_load;
  logic              out_valid_q;
  logic [12*SAMPLE_BITS-1:0] out_data_q;

  // Window memory: one word holds the x, y and z entries of a slot
  logic [3*SAMPLE_BITS-1:0] win_mem [WINDOW_MAX];
  logic [3*SAMPLE_BITS-1:0] rd_data_q;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     mem_we;

  // Divider
  logic              div_run_q;
  logic [1:0]        div_axis_q;
  logic [STEP_W-1:0] div_step_q;
  logic [SUM_W-1:0]  div_dq_q;
  logic [REM_W-1:0]  div_rem_q;
  logic              div_neg_q;
  sum_t              div_sum;
  logic [SUM_W-1:0]  div_mag;
  logic [REM_W:0]    rem_sh;
  logic              rem_ge;
  logic [REM_W:0]    rem_sub;
  sample_t           quot16;

  // Effective length and slot arithmetic
  always_comb begin
    if (len_q == '0) begin
      n_eff = LEN_W'(1);
    end else if (len_q > LEN_W'(WINDOW_MAX)) begin
      n_eff = LEN_W'(WINDOW_MAX);
    end else begin
      n_eff = len_q;
    end
  end

  assign slot_eff  = ({1'b0, slot_q} >= n_eff) ? '0 : slot_q;
  assign slot_inc  = {1'b0, slot_eff} + LEN_W'(1);
  assign scan_last = ({1'b0, scan_addr_q} == (n_eff - LEN_W'(1)));

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_load      = (state_q == S_FINISH) && !div_run_q
                         && (!out_valid_q || m_axis_tready);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_xfer) state_d = S_RDOLD;
      S_RDOLD:  state_d = S_UPDATE;
      S_UPDATE: state_d = full_q ? S_SCAN : S_IDLE;
      S_SCAN:   if (scan_last) state_d = S_DRAIN;
      S_DRAIN:  state_d = S_FINISH;
      S_FINISH: if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Length register, fill count, write slot and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LEN_RESET;
      items_q <= '0;
      slot_q  <= '0;
      full_q  <= 1'b0;
      for (int a = 0; a < AXES; a++) sums_q[a] <= '0;
    end else if (cfg_we_i) begin
      len_q   <= cfg_wdata_i;
      items_q <= '0;
      slot_q  <= '0;
      for (int a = 0; a < AXES; a++) sums_q[a] <= '0;
    end else begin
      if (in_xfer) begin
        full_q <= (items_q >= n_eff);
      end
      if (state_q == S_UPDATE) begin
        slot_q <= (slot_inc >= n_eff) ? '0 : slot_inc[ADDR_W-1:0];
        if (!full_q) items_q <= items_q + LEN_W'(1);
        for (int a = 0; a < AXES; a++) begin
          sums_q[a] <= sums_q[a] + SUM_W'(now_q[a])
                       - (full_q ? SUM_W'(sample_t'(rd_data_q[a*SAMPLE_BITS +:
                                                               SAMPLE_BITS]))
                                 : '0);
        end
      end
    end
  end

  // Captured samples
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int a = 0; a < AXES; a++) begin
        now_q[a] <= s_axis_tdata[a*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
  end

  // Window memory port: old entry read, then scan reads; write on update
  assign rd_addr = (state_q == S_RDOLD) ? slot_eff : scan_addr_q;
  assign mem_we  = (state_q == S_UPDATE);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[slot_eff] <= {now_q[2], now_q[1], now_q[0]};
    end
    rd_data_q <= win_mem[rd_addr];
  end

  // Scan address and read-valid tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q  <= '0;
      scan_vld_q   <= 1'b0;
      scan_first_q <= 1'b0;
    end else begin
      scan_vld_q <= (state_q == S_SCAN);
      if (state_q == S_UPDATE) begin
        scan_addr_q  <= '0;
        scan_first_q <= 1'b1;
      end else if (state_q == S_SCAN) begin
        scan_addr_q <= scan_addr_q + ADDR_W'(1);
      end
      if (scan_vld_q) scan_first_q <= 1'b0;
    end
  end

  // Min/max compare lanes on the registered read data
  always_ff @(posedge clk_i) begin
    if (scan_vld_q) begin
      for (int a = 0; a < AXES; a++) begin
        if (scan_first_q) begin
          lo_q[a] <= rd_data_q[a*SAMPLE_BITS +: SAMPLE_BITS];
          hi_q[a] <= rd_data_q[a*SAMPLE_BITS +: SAMPLE_BITS];
        end else begin
          if (sample_t'(rd_data_q[a*SAMPLE_BITS +: SAMPLE_BITS]) < lo_q[a])
            lo_q[a] <= rd_data_q[a*SAMPLE_BITS +: SAMPLE_BITS];
          if (sample_t'(rd_data_q[a*SAMPLE_BITS +: SAMPLE_BITS]) > hi_q[a])
            hi_q[a] <= rd_data_q[a*SAMPLE_BITS +: SAMPLE_BITS];
        end
      end
    end
  end

  // Shared restoring divider: |sum| / L, one quotient bit per cycle
  assign div_sum = sums_q[div_axis_q];
  assign div_mag = div_sum[SUM_W-1] ? (~div_sum + SUM_W'(1)) : div_sum;
  assign rem_sh  = {div_rem_q, div_dq_q[SUM_W-1]};
  assign rem_ge  = (rem_sh >= (REM_W+1)'(n_eff));
  assign rem_sub = rem_sh - (REM_W+1)'(n_eff);
  assign quot16  = div_neg_q ? (~div_dq_q[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1))
                             : div_dq_q[SAMPLE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_run_q  <= 1'b0;
      div_axis_q <= '0;
      div_step_q <= '0;
    end else if ((state_q == S_UPDATE) && full_q) begin
      div_run_q  <= 1'b1;
      div_axis_q <= '0;
      div_step_q <= '0;
    end else if (div_run_q) begin
      if (div_step_q == STEP_W'(DIV_STEPS + 1)) begin
        div_step_q <= '0;
        div_axis_q <= div_axis_q + 2'd1;
        if (div_axis_q == 2'(AXES - 1)) div_run_q <= 1'b0;
      end else begin
        div_step_q <= div_step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_run_q) begin
      if (div_step_q == '0) begin
        div_dq_q  <= div_mag;
        div_rem_q <= '0;
        div_neg_q <= div_sum[SUM_W-1];
      end else if (div_step_q == STEP_W'(DIV_STEPS + 1)) begin
        mean_q[div_axis_q] <= quot16;
      end else begin
        div_dq_q  <= {div_dq_q[SUM_W-2:0], rem_ge};
        div_rem_q <= rem_ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int a = 0; a < AXES; a++) begin
        out_data_q[(4*a+0)*SAMPLE_BITS +: SAMPLE_BITS] <= now_q[a];
        out_data_q[(4*a+1)*SAMPLE_BITS +: SAMPLE_BITS] <= mean_q[a];
        out_data_q[(4*a+2)*SAMPLE_BITS +: SAMPLE_BITS] <= lo_q[a];
        out_data_q[(4*a+3)*SAMPLE_BITS +: SAMPLE_BITS] <= hi_q[a];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  `SWA_ASSERT_NXT(a_busy_after_accept, in_xfer, !s_axis_tready)
  `SWA_ASSERT(a_fill_bounded, items_q <= n_eff)
  `SWA_ASSERT(a_slot_in_window, {1'b0, slot_q} < n_eff)
  `SWA_ASSERT_IMP(a_result_after_divide, out_load, !div_run_q && !scan_vld_q)
  `SWA_ASSERT_IMP(a_valid_rises_from_finish, $rose(out_valid_q),
                  $past(state_q) == S_FINISH)

endmodule

@@ bench/sliding_window_avg_min_max_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking stream testbench for the three-axis sliding window mean/min/max core.
module sliding_window_avg_min_max_core_tb;
  import swa_pkg::*;

  localparam int          CLK_HALF      = 6;
  localparam int          RESET_CYCLES  = 7;
  localparam int          NUM_FIELDS    = 4 * AXES;
  localparam int          RES_W         = NUM_FIELDS * SAMPLE_BITS;
  // well above the longest busy stretch of one sample
  localparam int          SETTLE_CYCLES = 1100;
  localparam int          HOLD_CYCLES   = 1500;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          NUM_PHASES    = 13;
  localparam int          HOLD_PHASE    = 2;
  localparam sample_t     S_MIN         = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam sample_t     S_MAX         = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  typedef struct packed {
    sample_t z;
    sample_t y;
    sample_t x;
  } accel_t;

  typedef logic [RES_W-1:0] stats_t;

  // which side throttles its handshake
  typedef enum logic [1:0] {
    MODE_RX_SLOW,
    MODE_TX_SLOW,
    MODE_FREE
  } idle_mode_e;

  // Length written per phase and number of result-giving samples in it
  int unsigned phase_len [NUM_PHASES] =
    '{0, 1, 2, 3, 5, 7, 150, 1, 31, 9, 4, 60, 16};
  int unsigned phase_results [NUM_PHASES] =
    '{20, 20, 25, 20, 25, 20, 10, 15, 15, 20, 20, 20, 25};

  string field_name [NUM_FIELDS] = '{
    "x_now", "x_mean", "x_least", "x_most",
    "y_now", "y_mean", "y_least", "y_most",
    "z_now", "z_mean", "z_least", "z_most"};

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [LEN_W-1:0]         cfg_wdata_i   = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [3*SAMPLE_BITS-1:0] s_axis_tdata  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [RES_W-1:0]         m_axis_tdata;

  // Stimulus bookkeeping
  accel_t     sample_fifo [$];
  stats_t     stats_due [$];
  int         n_pushed   = 0;
  int         n_taken    = 0;
  int         n_errors   = 0;
  int         cycle_count = 0;
  idle_mode_e idle_mode  = MODE_RX_SLOW;
  bit         hold_req   = 1'b0;
  bit         hold_done  = 1'b0;
  int         hold_left  = 0;

  // Predicted window state
  logic [LEN_W-1:0] win_len  = LEN_RESET;
  sample_t          win_mem [AXES][WINDOW_MAX];
  int               win_slot = 0;
  int               win_fill = 0;
  longint           win_sum [AXES] = '{default: 0};

  sliding_window_avg_min_max_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Enters one sample into the predicted windows; returns 1 with the expected
  // statistics once the window is full, 0 while it is still filling
  function automatic bit advance_window(input accel_t smp, output stats_t res);
    int      n;
    bit      full;
    sample_t now [AXES];
    sample_t lo;
    sample_t hi;
    longint  mean;
    n = (win_len == 0) ? 1 : (int'(win_len) > WINDOW_MAX) ? WINDOW_MAX : int'(win_len);
    full = (win_fill >= n);
    if (win_slot >= n) win_slot = 0;
    now[0] = smp.x;
    now[1] = smp.y;
    now[2] = smp.z;
    res = '0;
    for (int a = 0; a < AXES; a++) begin
      if (full) win_sum[a] -= longint'(win_mem[a][win_slot]);
      win_sum[a] += longint'(now[a]);
      win_mem[a][win_slot] = now[a];
    end
    win_slot = (win_slot + 1 >= n) ? 0 : win_slot + 1;
    if (!full) begin
      win_fill++;
      return 1'b0;
    end
    for (int a = 0; a < AXES; a++) begin
      lo = win_mem[a][0];
      hi = win_mem[a][0];
      for (int i = 1; i < n; i++) begin
        if (win_mem[a][i] < lo) lo = win_mem[a][i];
        if (win_mem[a][i] > hi) hi = win_mem[a][i];
      end
      // signed division truncates toward zero
      mean = win_sum[a] / n;
      res[(4*a+0)*SAMPLE_BITS +: SAMPLE_BITS] = now[a];
      res[(4*a+1)*SAMPLE_BITS +: SAMPLE_BITS] = sample_t'(mean);
      res[(4*a+2)*SAMPLE_BITS +: SAMPLE_BITS] = lo;
      res[(4*a+3)*SAMPLE_BITS +: SAMPLE_BITS] = hi;
    end
    return 1'b1;
  endfunction

  // Mix of extremes, values near zero and full-range noise
  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return S_MIN;
      1: return S_MAX;
      2: return sample_t'(int'($urandom_range(16)) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic queue_sample(input accel_t smp);
    sample_fifo.push_back(smp);
    n_pushed++;
  endtask

  // Block until every sample is taken and every result seen, then let the
  // core finish any filling sample still in flight
  task automatic wait_drained();
    while (n_taken != n_pushed || stats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sample driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_fifo.size() != 0 &&
            $urandom_range(99) >= ((idle_mode == MODE_RX_SLOW) ? 29 :
                                   (idle_mode == MODE_TX_SLOW) ? 66 : 0)) begin
          s_axis_tdata  <= sample_fifo.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver, with one long hold-off to back the core up
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_done) begin
        hold_done     <= 1'b1;
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(99) >= ((idle_mode == MODE_RX_SLOW) ? 66 :
                                                (idle_mode == MODE_TX_SLOW) ? 29 : 0);
      end
    end
  end

  // Monitor: tracks length writes, predicts on each input transfer and checks
  // each output transfer against the oldest prediction
  always @(posedge clk_i) begin : monitor
    stats_t want;
    stats_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        win_len  = cfg_wdata_i;
        win_fill = 0;
        win_slot = 0;
        win_sum  = '{default: 0};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (stats_due.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, got %h", $time, got);
          n_errors++;
        end else begin
          want = stats_due.pop_front();
          for (int f = 0; f < NUM_FIELDS; f++) begin
            if (got[f*SAMPLE_BITS +: SAMPLE_BITS] !== want[f*SAMPLE_BITS +: SAMPLE_BITS]) begin
              if (n_errors < 40)
                $display("%0t: %s expected %0d, got %0d", $time, field_name[f],
                         sample_t'(want[f*SAMPLE_BITS +: SAMPLE_BITS]),
                         sample_t'(got[f*SAMPLE_BITS +: SAMPLE_BITS]));
              n_errors++;
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n_taken++;
        if (advance_window(accel_t'(s_axis_tdata), want)) stats_due.push_back(want);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    accel_t      smp;
    int unsigned eff_len;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset length of 16: fill with opposite extremes, then swap them in;
    // small negative z sums check truncation toward zero
    for (int i = 0; i < 16; i++) begin
      smp.x = S_MIN;
      smp.y = S_MAX;
      smp.z = sample_t'((i % 3) - 1);
      queue_sample(smp);
    end
    for (int i = 0; i < 8; i++) begin
      smp.x = S_MAX;
      smp.y = S_MIN;
      smp.z = (i < 4) ? sample_t'(-1) : S_MIN;
      queue_sample(smp);
    end

    // Random phases, each after a length write while the core is idle
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      cfg_wdata_i <= LEN_W'(phase_len[p]);
      cfg_we_i    <= 1'b1;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      @(posedge clk_i);
      idle_mode = (p < 4) ? MODE_RX_SLOW : (p < 9) ? MODE_TX_SLOW : MODE_FREE;
      if (p == HOLD_PHASE) hold_req = 1'b1;
      eff_len = (phase_len[p] == 0) ? 1 :
                (phase_len[p] > WINDOW_MAX) ? WINDOW_MAX : phase_len[p];
      repeat (eff_len + phase_results[p]) begin
        smp.x = pick_sample();
        smp.y = pick_sample();
        smp.z = pick_sample();
        queue_sample(smp);
      end
    end

    wait_drained();
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
